/* hdl/fvl_pkg.sv */
// Shared types and constants for the FAT volume layout calculator.
// Used by every module under hdl; depends on nothing.
package fvl_pkg;

	localparam int unsigned SECTOR_BYTES = 512;
	localparam int unsigned FAT12_LIMIT  = 4085;
	localparam int unsigned FAT16_LIMIT  = 65525;
	localparam int unsigned DIV_CELLS    = 32;
	localparam int unsigned OFF_W        = 25;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_DISK_EMPTY  = 4'd1,
		ST_BAD_RANGE   = 4'd2,
		ST_SECTOR_SIZE = 4'd3,
		ST_ZERO_SPC    = 4'd4,
		ST_ZERO_RSV    = 4'd5,
		ST_ZERO_NFAT   = 4'd6,
		ST_ZERO_ROOT   = 4'd7,
		ST_ZERO_TOTAL  = 4'd8,
		ST_ZERO_SPF    = 4'd9,
		ST_OVF_VOLUME  = 4'd10,
		ST_OVF_RSV     = 4'd11,
		ST_OVF_FAT     = 4'd12,
		ST_OVF_ROOT    = 4'd13
	} status_t;

	typedef enum logic [1:0] {
		KIND_FAT12 = 2'd0,
		KIND_FAT16 = 2'd1,
		KIND_FAT32 = 2'd2
	} kind_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  spc;
		logic [7:0]  rem;
		logic [31:0] dq;
		logic [31:0] fat_start;
		logic [31:0] root_start;
		logic [31:0] data_start;
		logic [31:0] total;
	} div_t;

endpackage

/* hdl/fvl_front.sv */
// Front stages: field checks, FAT span, region offsets and the dividend.
// Three pipeline stages feeding the divider chain; uses fvl_pkg.
module fvl_front import fvl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] disk_sectors,
	input  logic [31:0] vol_base,
	input  logic [31:0] volume_sectors,
	input  logic [15:0] sector_size,
	input  logic [7:0]  cluster_size,
	input  logic [15:0] rsv_count,
	input  logic [7:0]  fat_count,
	input  logic [15:0] root_slots,
	input  logic [15:0] total_small,
	input  logic [31:0] total_large,
	input  logic [15:0] sectors_per_table,
	output logic        out_valid,
	input  logic        out_ready,
	output div_t        out_item
);

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	status_t     st_s1, st_s2;
	logic [31:0] start_s1, start_s2;
	logic [31:0] total_s1, total_s2;
	logic [15:0] rsv_s1, rsv_s2;
	logic [23:0] span_s1;
	logic [12:0] rspan_s1, rspan_s2;
	logic [7:0]  spc_s1, spc_s2;
	logic [OFF_W-1:0] rde_s2;
	div_t        item_s3;

	logic [31:0] total_c;
	logic [31:0] avail_c;
	status_t     st_c;
	logic [OFF_W-1:0] data_c;
	status_t     st3_c;

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign total_c = (total_small != 16'd0) ? {16'd0, total_small} : total_large;
	assign avail_c = disk_sectors - vol_base;

	always_comb begin
		priority if (disk_sectors == 32'd0) st_c = ST_DISK_EMPTY;
		else if (disk_sectors <= vol_base || avail_c < volume_sectors)
			st_c = ST_BAD_RANGE;
		else if (sector_size != 16'(SECTOR_BYTES)) st_c = ST_SECTOR_SIZE;
		else if (cluster_size == 8'd0) st_c = ST_ZERO_SPC;
		else if (rsv_count == 16'd0) st_c = ST_ZERO_RSV;
		else if (fat_count == 8'd0) st_c = ST_ZERO_NFAT;
		else if (root_slots == 16'd0) st_c = ST_ZERO_ROOT;
		else if (total_c == 32'd0) st_c = ST_ZERO_TOTAL;
		else if (sectors_per_table == 16'd0) st_c = ST_ZERO_SPF;
		else if (total_c > volume_sectors) st_c = ST_OVF_VOLUME;
		else if ({16'd0, rsv_count} > total_c) st_c = ST_OVF_RSV;
		else st_c = ST_OK;
	end

	assign data_c = rde_s2 + OFF_W'(rspan_s2);

	always_comb begin
		priority if (st_s2 != ST_OK) st3_c = st_s2;
		else if (32'(rde_s2) > total_s2) st3_c = ST_OVF_FAT;
		else if (32'(data_c) > total_s2) st3_c = ST_OVF_ROOT;
		else st3_c = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			st_s1    <= st_c;
			start_s1 <= vol_base;
			total_s1 <= total_c;
			rsv_s1   <= rsv_count;
			span_s1  <= 24'(sectors_per_table) * 24'(fat_count);
			rspan_s1 <= 13'((17'(root_slots) + 17'd15) >> 4);
			spc_s1   <= cluster_size;
		end
		if (rdy2 && v_s1) begin
			st_s2    <= st_s1;
			start_s2 <= start_s1;
			total_s2 <= total_s1;
			rsv_s2   <= rsv_s1;
			rde_s2   <= OFF_W'(rsv_s1) + OFF_W'(span_s1);
			rspan_s2 <= rspan_s1;
			spc_s2   <= spc_s1;
		end
		if (rdy3 && v_s2) begin
			item_s3.status     <= st3_c;
			item_s3.spc        <= spc_s2;
			item_s3.rem        <= 8'd0;
			item_s3.dq         <= total_s2 - 32'(data_c);
			item_s3.fat_start  <= start_s2 + 32'(rsv_s2);
			item_s3.root_start <= start_s2 + 32'(rde_s2);
			item_s3.data_start <= start_s2 + 32'(data_c);
			item_s3.total      <= total_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_item  = item_s3;

endmodule

/* hdl/fvl_div_cell.sv */
// One cell of the divider chain: resolves one quotient bit per item.
// Carries the rest of the item to its neighbor; uses fvl_pkg.
module fvl_div_cell import fvl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  div_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output div_t out_item
);

	logic       valid_q;
	div_t       item_q;
	logic [8:0] trial;
	logic [8:0] diff;
	logic       ge;
	div_t       nxt;

	assign in_ready = !valid_q || out_ready;
	assign trial    = {in_item.rem, in_item.dq[31]};
	assign diff     = trial - {1'b0, in_item.spc};
	assign ge       = trial >= {1'b0, in_item.spc};

	always_comb begin
		nxt     = in_item;
		nxt.rem = ge ? diff[7:0] : trial[7:0];
		nxt.dq  = {in_item.dq[30:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && item_q.spc != 8'd0 |-> item_q.rem < item_q.spc)
		else $error("remainder not below divisor");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |=> valid_q && $stable(item_q))
		else $error("cell item changed while stalled");

	a_ready_follows_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q |-> in_ready)
		else $error("empty cell not ready");

endmodule

/* hdl/fvl_out.sv */
// Output register: FAT type from the quotient and zeroing on failure.
// Final stage after the divider chain; uses fvl_pkg.
module fvl_out import fvl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  div_t        in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  status,
	output logic [1:0]  fat_kind,
	output logic [31:0] fat_region_start,
	output logic [31:0] root_region_start,
	output logic [31:0] data_region_start,
	output logic [31:0] cluster_count,
	output logic [31:0] total_used
);

	logic  valid_q;
	kind_t kind_c;
	logic  ok_c;

	assign in_ready = !valid_q || out_ready;
	assign ok_c     = in_item.status == ST_OK;

	always_comb begin
		priority if (in_item.dq <= 32'(FAT12_LIMIT)) kind_c = KIND_FAT12;
		else if (in_item.dq <= 32'(FAT16_LIMIT)) kind_c = KIND_FAT16;
		else kind_c = KIND_FAT32;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			status            <= in_item.status;
			fat_kind          <= ok_c ? kind_c : KIND_FAT12;
			fat_region_start  <= ok_c ? in_item.fat_start : 32'd0;
			root_region_start <= ok_c ? in_item.root_start : 32'd0;
			data_region_start <= ok_c ? in_item.data_start : 32'd0;
			cluster_count     <= ok_c ? in_item.dq : 32'd0;
			total_used        <= ok_c ? in_item.total : 32'd0;
		end
	end

	assign out_valid = valid_q;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> fat_kind == KIND_FAT12
		&& fat_region_start == 32'd0 && data_region_start == 32'd0
		&& cluster_count == 32'd0 && total_used == 32'd0)
		else $error("failure result carries nonzero fields");

	a_region_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> fat_region_start <= root_region_start
		&& root_region_start <= data_region_start)
		else $error("regions out of order");

	a_fat32_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK && cluster_count > 32'(FAT16_LIMIT)
		|-> fat_kind == KIND_FAT32)
		else $error("wrong FAT type for cluster count");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> cluster_count <= total_used)
		else $error("cluster count exceeds total");

endmodule

/* hdl/fat_volume_layout_calc_top.sv */
// FAT volume layout calculator, top level.
// Instantiates fvl_front, a row of fvl_div_cell and fvl_out; uses fvl_pkg.
//
// Input channel: in_valid/in_ready carry one volume description (disk size,
// volume start and length, parsed boot-sector fields). Output channel:
// out_valid/out_ready carry one result per item: status, FAT type, absolute
// first sectors of FAT, root directory and data, cluster count and total.
// A nonzero status reports the first failed check; other fields are then 0.
//
// Each item passes three check and offset stages, 32 divider cells that
// each resolve one quotient bit of the data sectors over cluster_size,
// and the output register. Every stage holds one item, so one item is
// accepted per cycle, sustained while the receiver keeps out_ready high.
//
// When the receiver stalls, the output and each stage behind it hold their
// item; empty stages keep filling, so up to 36 items are in flight before
// in_ready drops. Reset empties all stages at once; no clearing pass.
module fat_volume_layout_calc_top import fvl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] disk_sectors,
	input  logic [31:0] vol_base,
	input  logic [31:0] volume_sectors,
	input  logic [15:0] sector_size,
	input  logic [7:0]  cluster_size,
	input  logic [15:0] rsv_count,
	input  logic [7:0]  fat_count,
	input  logic [15:0] root_slots,
	input  logic [15:0] total_small,
	input  logic [31:0] total_large,
	input  logic [15:0] sectors_per_table,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  status,
	output logic [1:0]  fat_kind,
	output logic [31:0] fat_region_start,
	output logic [31:0] root_region_start,
	output logic [31:0] data_region_start,
	output logic [31:0] cluster_count,
	output logic [31:0] total_used
);

	logic chain_valid [0:DIV_CELLS];
	logic chain_ready [0:DIV_CELLS];
	div_t chain_item  [0:DIV_CELLS];

	fvl_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.disk_sectors      (disk_sectors),
		.vol_base          (vol_base),
		.volume_sectors    (volume_sectors),
		.sector_size       (sector_size),
		.cluster_size      (cluster_size),
		.rsv_count         (rsv_count),
		.fat_count         (fat_count),
		.root_slots        (root_slots),
		.total_small       (total_small),
		.total_large       (total_large),
		.sectors_per_table (sectors_per_table),
		.out_valid         (chain_valid[0]),
		.out_ready         (chain_ready[0]),
		.out_item          (chain_item[0])
	);

	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
		fvl_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_item   (chain_item[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_item  (chain_item[i+1])
		);
	end

	fvl_out u_out (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (chain_valid[DIV_CELLS]),
		.in_ready          (chain_ready[DIV_CELLS]),
		.in_item           (chain_item[DIV_CELLS]),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.status            (status),
		.fat_kind          (fat_kind),
		.fat_region_start  (fat_region_start),
		.root_region_start (root_region_start),
		.data_region_start (data_region_start),
		.cluster_count     (cluster_count),
		.total_used        (total_used)
	);

endmodule

/* bench/fat_volume_layout_calc_top_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for fat_volume_layout_calc_top: directed table, then random volumes.
// Each accepted item is tabled or predicted and matched in order with results; needs fvl_pkg.
module fat_volume_layout_calc_top_test import fvl_pkg::*;;

	typedef longint unsigned u64_t;

	typedef struct {
		logic [31:0] disk_sectors;
		logic [31:0] vol_base;
		logic [31:0] volume_sectors;
		logic [15:0] sector_size;
		logic [7:0]  cluster_size;
		logic [15:0] rsv_count;
		logic [7:0]  fat_count;
		logic [15:0] root_slots;
		logic [15:0] total_small;
		logic [31:0] total_large;
		logic [15:0] sectors_per_table;
	} volume_desc_t;

	typedef struct {
		status_t     status;
		kind_t       kind;
		logic [31:0] fat_start;
		logic [31:0] root_start;
		logic [31:0] data_start;
		logic [31:0] clusters;
		logic [31:0] total;
	} layout_t;

	typedef struct {
		volume_desc_t desc;
		bit           typed;
		layout_t      result;
	} table_row_t;

	localparam u64_t        MAX32              = 64'hFFFF_FFFF;
	localparam int unsigned ENTRIES_PER_SECTOR = 16;
	localparam int unsigned PIPE_LATENCY       = 36;
	localparam int unsigned RANDOM_ITEMS       = 1300;
	localparam int unsigned LONG_HOLD          = 200;
	localparam int unsigned HOLD_AFTER         = 400;
	localparam int unsigned STALL_LIMIT        = 2000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] disk_sectors;
	logic [31:0] vol_base;
	logic [31:0] volume_sectors;
	logic [15:0] sector_size;
	logic [7:0]  cluster_size;
	logic [15:0] rsv_count;
	logic [7:0]  fat_count;
	logic [15:0] root_slots;
	logic [15:0] total_small;
	logic [31:0] total_large;
	logic [15:0] sectors_per_table;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  status;
	logic [1:0]  fat_kind;
	logic [31:0] fat_region_start;
	logic [31:0] root_region_start;
	logic [31:0] data_region_start;
	logic [31:0] cluster_count;
	logic [31:0] total_used;

	layout_t     expected_layouts[$];
	table_row_t  directed_rows[$];
	int unsigned items_sent;
	int unsigned layouts_checked;
	int unsigned results_taken;
	int unsigned mismatches;
	int unsigned idle_cycles;
	int unsigned status_seen[16];
	int unsigned kind_seen[4];
	bit          hold_active;
	bit          hold_done;

	fat_volume_layout_calc_top dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.disk_sectors        (disk_sectors),
		.vol_base            (vol_base),
		.volume_sectors      (volume_sectors),
		.sector_size         (sector_size),
		.cluster_size        (cluster_size),
		.rsv_count           (rsv_count),
		.fat_count           (fat_count),
		.root_slots          (root_slots),
		.total_small         (total_small),
		.total_large         (total_large),
		.sectors_per_table   (sectors_per_table),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.status              (status),
		.fat_kind            (fat_kind),
		.fat_region_start    (fat_region_start),
		.root_region_start   (root_region_start),
		.data_region_start   (data_region_start),
		.cluster_count       (cluster_count),
		.total_used          (total_used)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic layout_t fail_layout(status_t code);
		layout_t r;
		r = '{code, KIND_FAT12, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
		return r;
	endfunction

	function automatic volume_desc_t mk_volume(logic [31:0] disk, logic [31:0] start,
			logic [31:0] vol, logic [15:0] bps, logic [7:0] spc, logic [15:0] rsv,
			logic [7:0] nfat, logic [15:0] rootn, logic [15:0] tsmall,
			logic [31:0] tlarge, logic [15:0] spf);
		volume_desc_t v;
		v = '{disk, start, vol, bps, spc, rsv, nfat, rootn, tsmall, tlarge, spf};
		return v;
	endfunction

	function automatic layout_t predict_layout(volume_desc_t v);
		layout_t r;
		u64_t    total;
		u64_t    fat_span;
		u64_t    root_off;
		u64_t    root_span;
		u64_t    data_off;
		u64_t    clusters;
		if (v.disk_sectors == 0)
			return fail_layout(ST_DISK_EMPTY);
		if (v.disk_sectors <= v.vol_base ||
				v.disk_sectors - v.vol_base < v.volume_sectors)
			return fail_layout(ST_BAD_RANGE);
		if (v.sector_size != SECTOR_BYTES)
			return fail_layout(ST_SECTOR_SIZE);
		total = (v.total_small != 0) ? u64_t'(v.total_small) : u64_t'(v.total_large);
		if (v.cluster_size == 0)
			return fail_layout(ST_ZERO_SPC);
		if (v.rsv_count == 0)
			return fail_layout(ST_ZERO_RSV);
		if (v.fat_count == 0)
			return fail_layout(ST_ZERO_NFAT);
		if (v.root_slots == 0)
			return fail_layout(ST_ZERO_ROOT);
		if (total == 0)
			return fail_layout(ST_ZERO_TOTAL);
		if (v.sectors_per_table == 0)
			return fail_layout(ST_ZERO_SPF);
		if (total > v.volume_sectors)
			return fail_layout(ST_OVF_VOLUME);
		if (v.rsv_count > total)
			return fail_layout(ST_OVF_RSV);
		fat_span = u64_t'(v.sectors_per_table) * u64_t'(v.fat_count);
		if (fat_span > total - u64_t'(v.rsv_count))
			return fail_layout(ST_OVF_FAT);
		root_off = u64_t'(v.rsv_count) + fat_span;
		root_span = (u64_t'(v.root_slots) + ENTRIES_PER_SECTOR - 1) / ENTRIES_PER_SECTOR;
		if (root_span > total - root_off)
			return fail_layout(ST_OVF_ROOT);
		data_off = root_off + root_span;
		clusters = (total - data_off) / u64_t'(v.cluster_size);
		r.status = ST_OK;
		if (clusters <= FAT12_LIMIT)
			r.kind = KIND_FAT12;
		else if (clusters <= FAT16_LIMIT)
			r.kind = KIND_FAT16;
		else
			r.kind = KIND_FAT32;
		r.fat_start  = 32'(u64_t'(v.vol_base) + u64_t'(v.rsv_count));
		r.root_start = 32'(u64_t'(v.vol_base) + root_off);
		r.data_start = 32'(u64_t'(v.vol_base) + data_off);
		r.clusters   = 32'(clusters);
		r.total      = 32'(total);
		return r;
	endfunction

	// Mostly consistent volumes with random geometry; some noise, some with one field broken.
	function automatic volume_desc_t random_volume();
		volume_desc_t v;
		u64_t        root_span;
		u64_t        data_off;
		u64_t        clusters;
		u64_t        total;
		u64_t        vol;
		u64_t        room;
		u64_t        start;
		u64_t        disk;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			v = mk_volume($urandom, $urandom, $urandom, 16'($urandom), 8'($urandom),
				16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), $urandom,
				16'($urandom));
			if ($urandom_range(0, 1))
				v.sector_size = 16'(SECTOR_BYTES);
			return v;
		end
		v.sector_size = 16'(SECTOR_BYTES);
		v.cluster_size = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
			: 8'(32'd1 << $urandom_range(0, 7));
		v.rsv_count = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
			: 16'($urandom_range(1, 64));
		v.fat_count = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255))
			: 8'($urandom_range(1, 2));
		v.sectors_per_table = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
			: 16'($urandom_range(1, 512));
		v.root_slots = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
			: 16'($urandom_range(1, 1024));
		root_span = (u64_t'(v.root_slots) + ENTRIES_PER_SECTOR - 1) / ENTRIES_PER_SECTOR;
		data_off = u64_t'(v.rsv_count) + u64_t'(v.fat_count) * u64_t'(v.sectors_per_table)
			+ root_span;
		case ($urandom_range(0, 3))
			0: clusters = u64_t'($urandom_range(0, 4100));
			1: clusters = u64_t'($urandom_range(4080, 65540));
			2: clusters = u64_t'($urandom_range(65520, 70000));
			default: clusters = u64_t'($urandom);
		endcase
		total = data_off + clusters * u64_t'(v.cluster_size)
			+ u64_t'($urandom_range(0, 32'(v.cluster_size) - 1));
		if (total > MAX32)
			total = MAX32 - u64_t'($urandom_range(0, 1000));
		if (total < 65536 && $urandom_range(0, 1)) begin
			v.total_small = 16'(total);
			v.total_large = $urandom;
		end else begin
			v.total_small = 16'd0;
			v.total_large = 32'(total);
		end
		vol = total;
		if ($urandom_range(0, 1))
			vol += u64_t'($urandom_range(0, 100000));
		if (vol > MAX32)
			vol = MAX32;
		room = MAX32 - vol;
		start = $urandom_range(0, 1) ? u64_t'($urandom_range(0, 1000000)) : u64_t'($urandom);
		start = start % (room + 1);
		disk = start + vol;
		if ($urandom_range(0, 1))
			disk += u64_t'($urandom) % (room - start + 1);
		v.disk_sectors = 32'(disk);
		v.vol_base = 32'(start);
		v.volume_sectors = 32'(vol);
		if (pick < 30) begin
			case ($urandom_range(0, 14))
				0: v.disk_sectors = 32'd0;
				1: v.vol_base = v.disk_sectors;
				2: v.volume_sectors = v.disk_sectors - v.vol_base + 32'd1;
				3: v.sector_size = 16'($urandom);
				4: v.cluster_size = 8'd0;
				5: v.rsv_count = 16'd0;
				6: v.fat_count = 8'd0;
				7: v.root_slots = 16'd0;
				8: begin
					v.total_small = 16'd0;
					v.total_large = 32'd0;
				end
				9: v.sectors_per_table = 16'd0;
				10: v.volume_sectors = 32'(total - 1);
				11: v.rsv_count = 16'($urandom);
				12: v.sectors_per_table = 16'($urandom);
				13: v.root_slots = 16'($urandom);
				default: v.fat_count = 8'($urandom);
			endcase
		end
		return v;
	endfunction

	function automatic int unsigned idle_draw(int unsigned idx);
		return ((idx / 64) % 4 == 3) ? 0 : $urandom_range(0, 8);
	endfunction

	task automatic add_row(volume_desc_t d, bit typed, layout_t r);
		table_row_t row;
		row = '{d, typed, r};
		directed_rows.push_back(row);
	endtask

	task automatic send_volume(volume_desc_t v, bit typed, layout_t typed_result);
		int unsigned gap;
		gap = hold_active ? 0 : idle_draw(items_sent);
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		disk_sectors        = v.disk_sectors;
		vol_base            = v.vol_base;
		volume_sectors      = v.volume_sectors;
		sector_size         = v.sector_size;
		cluster_size        = v.cluster_size;
		rsv_count           = v.rsv_count;
		fat_count           = v.fat_count;
		root_slots          = v.root_slots;
		total_small         = v.total_small;
		total_large         = v.total_large;
		sectors_per_table   = v.sectors_per_table;
		in_valid            = 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_layouts.push_back(typed ? typed_result : predict_layout(v));
		items_sent++;
	endtask

	task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		layout_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_layouts.size() == 0) begin
				$display("%0t: result with no item pending, expected none, actual status %0h",
					$time, status);
				mismatches++;
			end else begin
				want = expected_layouts.pop_front();
				report_field("status", 32'(want.status), 32'(status));
				report_field("fat_kind", 32'(want.kind), 32'(fat_kind));
				report_field("fat_region_start", want.fat_start, fat_region_start);
				report_field("root_region_start", want.root_start, root_region_start);
				report_field("data_region_start", want.data_start, data_region_start);
				report_field("cluster_count", want.clusters, cluster_count);
				report_field("total_used", want.total, total_used);
				status_seen[want.status]++;
				if (want.status == ST_OK)
					kind_seen[want.kind]++;
				layouts_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, idle_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int unsigned stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!hold_done && results_taken >= HOLD_AFTER) begin
				hold_active = 1'b1;
				hold_done   = 1'b1;
				stall       = LONG_HOLD;
			end else begin
				stall = idle_draw(results_taken);
			end
			@(negedge clk);
			if (stall != 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			hold_active = 1'b0;
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			results_taken++;
		end
	end

	initial begin
		layout_t     widest;
		int unsigned directed_count;
		int unsigned codes_hit;
		arst_n              = 1'b0;
		in_valid            = 1'b0;
		disk_sectors        = '0;
		vol_base            = '0;
		volume_sectors      = '0;
		sector_size         = '0;
		cluster_size        = '0;
		rsv_count           = '0;
		fat_count           = '0;
		root_slots          = '0;
		total_small         = '0;
		total_large         = '0;
		sectors_per_table   = '0;
		items_sent          = 0;
		layouts_checked     = 0;
		results_taken       = 0;
		mismatches          = 0;
		idle_cycles         = 0;
		hold_active         = 1'b0;
		hold_done           = 1'b0;
		foreach (status_seen[i]) status_seen[i] = 0;
		foreach (kind_seen[i]) kind_seen[i] = 0;

		widest = '{ST_OK, KIND_FAT32, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFC, 32'hFFFF_FFFF};
		add_row(mk_volume(0, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1), 1,
			fail_layout(ST_DISK_EMPTY));
		add_row(mk_volume(1, 1, 0, 512, 8, 32, 2, 512, 0, 500000, 256), 1,
			fail_layout(ST_BAD_RANGE));
		add_row(mk_volume('1, '1, 0, 512, 8, 32, 2, 512, 0, 500000, 256), 1,
			fail_layout(ST_BAD_RANGE));
		add_row(mk_volume(1000, 10, 991, 512, 8, 32, 2, 512, 0, 500, 256), 1,
			fail_layout(ST_BAD_RANGE));
		add_row(mk_volume(1000000, 2048, 900000, 0, 8, 32, 2, 512, 0, 500000, 256), 1,
			fail_layout(ST_SECTOR_SIZE));
		add_row(mk_volume(1000000, 2048, 900000, '1, 8, 32, 2, 512, 0, 500000, 256), 1,
			fail_layout(ST_SECTOR_SIZE));
		add_row(mk_volume(1000000, 2048, 900000, 513, 8, 32, 2, 512, 0, 500000, 256), 1,
			fail_layout(ST_SECTOR_SIZE));
		add_row(mk_volume(1000000, 2048, 900000, 512, 0, 32, 2, 512, 0, 500000, 256), 1,
			fail_layout(ST_ZERO_SPC));
		add_row(mk_volume(1000000, 2048, 900000, 512, 8, 0, 2, 512, 0, 500000, 256), 1,
			fail_layout(ST_ZERO_RSV));
		add_row(mk_volume(1000000, 2048, 900000, 512, 8, 32, 0, 512, 0, 500000, 256), 1,
			fail_layout(ST_ZERO_NFAT));
		add_row(mk_volume(1000000, 2048, 900000, 512, 8, 32, 2, 0, 0, 500000, 256), 1,
			fail_layout(ST_ZERO_ROOT));
		add_row(mk_volume(1000000, 2048, 900000, 512, 8, 32, 2, 512, 0, 0, 256), 1,
			fail_layout(ST_ZERO_TOTAL));
		add_row(mk_volume(1000000, 2048, 900000, 512, 8, 32, 2, 512, 0, 500000, 0), 1,
			fail_layout(ST_ZERO_SPF));
		add_row(mk_volume(1000000, 2048, 900000, 512, 8, 32, 2, 512, 0, 900001, 256), 1,
			fail_layout(ST_OVF_VOLUME));
		add_row(mk_volume(1000000, 2048, 900000, 512, 8, 32, 2, 512, 16, 500000, 256), 1,
			fail_layout(ST_OVF_RSV));
		add_row(mk_volume(1000000, 2048, 900000, 512, 8, 32, 2, 512, 543, 500000, 256), 1,
			fail_layout(ST_OVF_FAT));
		add_row(mk_volume(1000000, 2048, 900000, 512, 8, 32, 2, 512, 575, 500000, 256), 1,
			fail_layout(ST_OVF_ROOT));
		add_row(mk_volume(1000000, 2048, 900000, 512, 8, 32, 2, 512, 0, 500000, 256), 0,
			fail_layout(ST_OK));
		add_row(mk_volume(1000000, 2048, 900000, 512, 8, 32, 2, 512, 576, 500000, 256), 0,
			fail_layout(ST_OK));
		add_row(mk_volume('1, 0, '1, 512, 1, 1, 1, 1, 0, '1, 1), 1, widest);
		add_row(mk_volume('1, 0, '1, 512, '1, '1, '1, '1, 0, '1, '1), 0,
			fail_layout(ST_OK));
		add_row(mk_volume('1, 32'hFFFF_FFFE, 1, 512, 1, 1, 1, 1, 1, 0, 1), 0,
			fail_layout(ST_OK));
		add_row(mk_volume(100000, 0, 70000, 512, 1, 1, 1, 16, 4088, 0, 1), 0,
			fail_layout(ST_OK));
		add_row(mk_volume(100000, 0, 70000, 512, 1, 1, 1, 16, 4089, 0, 1), 0,
			fail_layout(ST_OK));
		add_row(mk_volume(100000, 0, 70000, 512, 1, 1, 1, 16, 65528, 0, 1), 0,
			fail_layout(ST_OK));
		add_row(mk_volume(100000, 0, 70000, 512, 1, 1, 1, 16, 65529, 0, 1), 0,
			fail_layout(ST_OK));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_volume(directed_rows[i].desc, directed_rows[i].typed, directed_rows[i].result);
		directed_count = items_sent;
		repeat (RANDOM_ITEMS)
			send_volume(random_volume(), 1'b0, fail_layout(ST_OK));
		@(negedge clk);
		in_valid = 1'b0;

		while (expected_layouts.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);

		codes_hit = 0;
		for (int s = 0; s <= ST_OVF_ROOT; s++)
			if (status_seen[s] != 0)
				codes_hit++;
		$display("Sent %0d volume items (%0d directed, %0d random), checked %0d layouts.",
			items_sent, directed_count, items_sent - directed_count, layouts_checked);
		$display("Status codes hit: %0d of 14; FAT12/16/32 layouts: %0d/%0d/%0d; %0d mismatches.",
			codes_hit, kind_seen[KIND_FAT12], kind_seen[KIND_FAT16], kind_seen[KIND_FAT32],
			mismatches);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
